[src/rsi_pkg.sv]
// rsi_pkg: shared widths, constants, sequencer states, step-unit request type
// and result type for the relative strength index block
// no dependencies

package rsi_pkg;

    localparam int CLOSE_W    = 31;
    localparam int PERIOD_W   = 8;
    localparam int SAMPLES_W  = 9;
    localparam int AVG_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int RSI_W      = 23;
    localparam int DIVIDEND_W = AVG_W + FRAC_BITS;
    localparam int REM_W      = AVG_W + 2;
    localparam int DIV_CNT_W  = 6;
    localparam int RATIO_BITS = RSI_W;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET   = 8'd14;
    localparam logic [SAMPLES_W-1:0] SMOOTHING_MARK = 9'd256;
    localparam logic [RSI_W-1:0]     RSI_FULL       = RSI_W'(100 << FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_RSI,
        ST_RATIO,
        ST_DONE
    } rsi_state_t;

    // one request to the shared step unit
    typedef struct packed {
        logic mode_add;
        logic bit_in;
    } step_req_t;

    // one finished result from the core
    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic             ready_res;
    } rsi_result_t;

endpackage

[src/rsi_step_unit.sv]
// rsi_step_unit: one restoring divide / scaled ratio step (shift or add, then compare
// and subtract); shared by every division in the block
// depends on rsi_pkg

module rsi_step_unit (
    input  rsi_pkg::step_req_t            req,
    input  logic [rsi_pkg::REM_W-1:0]     rem_i,
    input  logic [rsi_pkg::REM_W-1:0]     addend_i,
    input  logic [rsi_pkg::REM_W-1:0]     divisor_i,
    output logic [rsi_pkg::REM_W-1:0]     rem_o,
    output logic                          q_o
);

    logic [rsi_pkg::REM_W-1:0] trial;

    always_comb begin
        if (req.mode_add) begin
            trial = rem_i + addend_i;
        end else begin
            trial = {rem_i[rsi_pkg::REM_W-2:0], req.bit_in};
        end
        q_o   = (trial >= divisor_i);
        rem_o = q_o ? (trial - divisor_i) : trial;
    end

endmodule

[src/rsi_core.sv]
// rsi_core: sequencer and state for the rsi computation; runs the divisions
// and the final ratio through the shared step unit
// depends on rsi_pkg, rsi_step_unit

module rsi_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start_i,
    input  logic                             start_of_series_i,
    input  logic [rsi_pkg::CLOSE_W-1:0]      close_price_i,
    input  logic [rsi_pkg::PERIOD_W-1:0]     period_i,
    output logic                             idle_o,
    output logic                             res_valid_o,
    output rsi_pkg::rsi_result_t             res_o,
    input  logic                             res_ack_i
);

    rsi_pkg::rsi_state_t state_reg, state_next;

    logic [rsi_pkg::CLOSE_W-1:0]    last_close_reg, last_close_next;
    logic [rsi_pkg::SAMPLES_W-1:0]  samples_reg, samples_next;
    logic [rsi_pkg::AVG_W-1:0]      gain_avg_reg, gain_avg_next;
    logic [rsi_pkg::AVG_W-1:0]      loss_avg_reg, loss_avg_next;
    logic [rsi_pkg::CLOSE_W-1:0]    gain_diff_reg, gain_diff_next;
    logic [rsi_pkg::CLOSE_W-1:0]    loss_diff_reg, loss_diff_next;
    logic [rsi_pkg::PERIOD_W-1:0]   period_reg, period_next;
    logic [rsi_pkg::DIVIDEND_W-1:0] dividend_reg, dividend_next;
    logic [rsi_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [rsi_pkg::AVG_W-1:0]      quot_reg, quot_next;
    logic [rsi_pkg::AVG_W:0]        den_reg, den_next;
    logic [rsi_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           side_reg, side_next;
    logic                           add_phase_reg, add_phase_next;
    logic [rsi_pkg::RSI_W-1:0]      rsi_reg, rsi_next;
    logic                           ready_reg, ready_next;

    rsi_pkg::step_req_t             step_req;
    logic [rsi_pkg::REM_W-1:0]      step_addend;
    logic [rsi_pkg::REM_W-1:0]      step_divisor;
    logic [rsi_pkg::REM_W-1:0]      step_rem;
    logic                           step_q;

    logic [rsi_pkg::AVG_W-1:0]      avg_sel;
    logic [rsi_pkg::CLOSE_W-1:0]    diff_sel;
    logic [rsi_pkg::AVG_W+rsi_pkg::PERIOD_W-1:0] smooth_prod;
    logic                           warm;

    rsi_step_unit u_step (
        .req       (step_req),
        .rem_i     (rem_reg),
        .addend_i  (step_addend),
        .divisor_i (step_divisor),
        .rem_o     (step_rem),
        .q_o       (step_q)
    );

    assign warm        = !samples_reg[rsi_pkg::SAMPLES_W-1];
    assign avg_sel     = side_reg ? loss_avg_reg : gain_avg_reg;
    assign diff_sel    = side_reg ? loss_diff_reg : gain_diff_reg;
    assign smooth_prod = (rsi_pkg::AVG_W + rsi_pkg::PERIOD_W)'(avg_sel)
                       * (rsi_pkg::AVG_W + rsi_pkg::PERIOD_W)'(period_reg - 8'd1);

    assign idle_o      = (state_reg == rsi_pkg::ST_IDLE);
    assign res_valid_o = (state_reg == rsi_pkg::ST_DONE);
    assign res_o.rsi_value = rsi_reg;
    assign res_o.ready_res = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rsi_pkg::ST_IDLE;
            last_close_reg <= '0;
            samples_reg    <= '0;
            gain_avg_reg   <= '0;
            loss_avg_reg   <= '0;
            cnt_reg        <= '0;
            side_reg       <= 1'b0;
            add_phase_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_close_reg <= last_close_next;
            samples_reg    <= samples_next;
            gain_avg_reg   <= gain_avg_next;
            loss_avg_reg   <= loss_avg_next;
            cnt_reg        <= cnt_next;
            side_reg       <= side_next;
            add_phase_reg  <= add_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_diff_reg <= gain_diff_next;
        loss_diff_reg <= loss_diff_next;
        period_reg    <= period_next;
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        den_reg       <= den_next;
        rsi_reg       <= rsi_next;
        ready_reg     <= ready_next;
    end

    always_comb begin
        state_next      = state_reg;
        last_close_next = last_close_reg;
        samples_next    = samples_reg;
        gain_avg_next   = gain_avg_reg;
        loss_avg_next   = loss_avg_reg;
        gain_diff_next  = gain_diff_reg;
        loss_diff_next  = loss_diff_reg;
        period_next     = period_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        den_next        = den_reg;
        cnt_next        = cnt_reg;
        side_next       = side_reg;
        add_phase_next  = add_phase_reg;
        rsi_next        = rsi_reg;
        ready_next      = ready_reg;

        step_req.mode_add = 1'b0;
        step_req.bit_in   = 1'b0;
        step_addend       = '0;
        step_divisor      = rsi_pkg::REM_W'(period_reg);

        case (state_reg)
            rsi_pkg::ST_IDLE: begin
                if (start_i) begin
                    period_next     = period_i;
                    last_close_next = close_price_i;
                    if (start_of_series_i || samples_reg == '0) begin
                        samples_next  = 9'd1;
                        gain_avg_next = '0;
                        loss_avg_next = '0;
                        rsi_next      = '0;
                        ready_next    = 1'b0;
                        state_next    = rsi_pkg::ST_DONE;
                    end else begin
                        if (close_price_i > last_close_reg) begin
                            gain_diff_next = close_price_i - last_close_reg;
                            loss_diff_next = '0;
                        end else begin
                            gain_diff_next = '0;
                            loss_diff_next = last_close_reg - close_price_i;
                        end
                        side_next  = 1'b0;
                        state_next = warm ? rsi_pkg::ST_ACCUM : rsi_pkg::ST_LOAD;
                    end
                end
            end

            rsi_pkg::ST_ACCUM: begin
                gain_avg_next = gain_avg_reg + rsi_pkg::AVG_W'(gain_diff_reg);
                loss_avg_next = loss_avg_reg + rsi_pkg::AVG_W'(loss_diff_reg);
                if (samples_reg >= rsi_pkg::SAMPLES_W'(period_reg)) begin
                    state_next = rsi_pkg::ST_LOAD;
                end else begin
                    samples_next = samples_reg + 9'd1;
                    rsi_next     = '0;
                    ready_next   = 1'b0;
                    state_next   = rsi_pkg::ST_DONE;
                end
            end

            rsi_pkg::ST_LOAD: begin
                // warm-up: sum << frac; smoothing: avg*(p-1) + (x << frac)
                if (warm) begin
                    dividend_next = {avg_sel, {rsi_pkg::FRAC_BITS{1'b0}}};
                end else begin
                    dividend_next = rsi_pkg::DIVIDEND_W'(smooth_prod
                        + (rsi_pkg::AVG_W + rsi_pkg::PERIOD_W)'(
                            {diff_sel, {rsi_pkg::FRAC_BITS{1'b0}}}));
                end
                rem_next   = '0;
                quot_next  = '0;
                cnt_next   = rsi_pkg::DIV_CNT_W'(rsi_pkg::DIVIDEND_W - 1);
                state_next = rsi_pkg::ST_DIV;
            end

            rsi_pkg::ST_DIV: begin
                step_req.bit_in = dividend_reg[rsi_pkg::DIVIDEND_W-1];
                rem_next        = step_rem;
                quot_next       = {quot_reg[rsi_pkg::AVG_W-2:0], step_q};
                dividend_next   = {dividend_reg[rsi_pkg::DIVIDEND_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    if (!side_reg) begin
                        gain_avg_next = quot_next;
                        side_next     = 1'b1;
                        state_next    = rsi_pkg::ST_LOAD;
                    end else begin
                        loss_avg_next = quot_next;
                        samples_next  = rsi_pkg::SMOOTHING_MARK;
                        state_next    = rsi_pkg::ST_RSI;
                    end
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end

            rsi_pkg::ST_RSI: begin
                ready_next = 1'b1;
                if (loss_avg_reg == '0) begin
                    rsi_next   = rsi_pkg::RSI_FULL;
                    state_next = rsi_pkg::ST_DONE;
                end else begin
                    den_next       = {1'b0, gain_avg_reg} + {1'b0, loss_avg_reg};
                    rem_next       = '0;
                    quot_next      = '0;
                    cnt_next       = rsi_pkg::DIV_CNT_W'(rsi_pkg::RATIO_BITS - 1);
                    add_phase_next = 1'b0;
                    state_next     = rsi_pkg::ST_RATIO;
                end
            end

            rsi_pkg::ST_RATIO: begin
                // floor(g * full / (g + l)), one bit of full per shift step
                step_req.mode_add = add_phase_reg;
                step_addend       = rsi_pkg::REM_W'(gain_avg_reg);
                step_divisor      = rsi_pkg::REM_W'(den_reg);
                rem_next          = step_rem;
                if (add_phase_reg) begin
                    quot_next = quot_reg + rsi_pkg::AVG_W'(step_q);
                end else begin
                    quot_next = {quot_reg[rsi_pkg::AVG_W-2:0], 1'b0}
                              + rsi_pkg::AVG_W'(step_q);
                end
                if (!add_phase_reg && rsi_pkg::RSI_FULL[cnt_reg[4:0]]) begin
                    add_phase_next = 1'b1;
                end else begin
                    add_phase_next = 1'b0;
                    if (cnt_reg == '0) begin
                        rsi_next   = quot_next[rsi_pkg::RSI_W-1:0];
                        state_next = rsi_pkg::ST_DONE;
                    end else begin
                        cnt_next = cnt_reg - 6'd1;
                    end
                end
            end

            rsi_pkg::ST_DONE: begin
                if (res_ack_i) begin
                    state_next = rsi_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rsi_pkg::ST_IDLE;
            end
        endcase
    end

    // remainder of a period division stays below the period
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsi_pkg::ST_DIV) |-> (rem_reg < rsi_pkg::REM_W'(period_reg)))
        else $error("division remainder not below period");

    // ratio remainder stays below g + l
    a_ratio_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsi_pkg::ST_RATIO) |-> (rem_reg < rsi_pkg::REM_W'(den_reg)))
        else $error("ratio remainder not below denominator");

    // warm-up results carry zero, real results never exceed 100
    a_warm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_o && !ready_reg) |-> (rsi_reg == '0))
        else $error("warm-up result not zero");

    a_rsi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_o |-> (rsi_reg <= rsi_pkg::RSI_FULL))
        else $error("rsi above full scale");

    // an accepted request always leaves idle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (idle_o && start_i) |=> !idle_o)
        else $error("request accepted but sequencer stayed idle");

endmodule

[src/relative_strength_index.sv]
// relative_strength_index: top level; period register, request handshake,
// result output register
// depends on rsi_pkg, rsi_core (which uses rsi_step_unit)
//
// usage
//   - one request per candle: s_close_price with s_start_of_series; one result per
//     request on the m_ channel: m_rsi_value (0..100, 16 fraction bits) and
//     m_ready_res (0 while the series is still warming up, then rsi_value is 0)
//   - cfg_wr_en / cfg_wr_data write the smoothing period (0 acts as 1); write it
//     only while no request is in flight
//   - from accept, a series start goes straight to the result, a warm-up close
//     passes the accumulate state, and a close that yields an rsi runs two 64-step
//     period divisions and a 26-step ratio, all through the one shared step unit
//   - s_ready is low while a request is being worked on, so a new request is taken
//     only once the core is through with the last one
//   - reset (aresetn low, synchronous) sets the period to 14 and clears the
//     series state; the first request after reset starts a new series
//   - when m_ready is low the result waits in the output register; the next
//     request is still accepted and computed, and waits in the core until the
//     output register frees

module relative_strength_index (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]     cfg_wr_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_start_of_series,
    input  logic [rsi_pkg::CLOSE_W-1:0]      s_close_price,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rsi_pkg::RSI_W-1:0]        m_rsi_value,
    output logic                             m_ready_res
);

    // period register
    logic [rsi_pkg::PERIOD_W-1:0] period_reg;
    logic [rsi_pkg::PERIOD_W-1:0] period_eff;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [rsi_pkg::RSI_W-1:0]    m_rsi_value_reg, m_rsi_value_next;
    logic                         m_ready_res_reg, m_ready_res_next;

    // core handshake
    logic                         core_idle;
    logic                         core_res_valid;
    rsi_pkg::rsi_result_t         core_res;
    logic                         res_ack;
    logic                         req_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= rsi_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    // a period of zero behaves as one
    assign period_eff = (period_reg == '0) ? 8'd1 : period_reg;

    assign s_ready    = core_idle;
    assign req_accept = s_valid && core_idle;

    // the core hands its result over once the output register is free or draining
    assign res_ack = core_res_valid && (!m_valid_reg || m_ready);

    rsi_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start_i           (req_accept),
        .start_of_series_i (s_start_of_series),
        .close_price_i     (s_close_price),
        .period_i          (period_eff),
        .idle_o            (core_idle),
        .res_valid_o       (core_res_valid),
        .res_o             (core_res),
        .res_ack_i         (res_ack)
    );

    always_comb begin
        m_valid_next     = m_valid_reg;
        m_rsi_value_next = m_rsi_value_reg;
        m_ready_res_next = m_ready_res_reg;
        if (res_ack) begin
            m_valid_next     = 1'b1;
            m_rsi_value_next = core_res.rsi_value;
            m_ready_res_next = core_res.ready_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_rsi_value_reg <= m_rsi_value_next;
        m_ready_res_reg <= m_ready_res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_rsi_value = m_rsi_value_reg;
    assign m_ready_res = m_ready_res_reg;

endmodule
